// File: hw/rtl/position_pid_filtered_derivative_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the position PID block
// Shared property templates used by the port checker.
// ---------------------------------------------------------------------------
`ifndef POSITION_PID_FILTERED_DERIVATIVE_TOP_DEFINES_SVH
`define POSITION_PID_FILTERED_DERIVATIVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPD_ASSERT_SAME(lbl, clock, reset_n, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPD_ASSERT_NEXT(lbl, clock, reset_n, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ppd_pkg.sv
// ---------------------------------------------------------------------------
// ppd_pkg
// Widths, constants and shared types of the position PID block.
// ---------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

  localparam int WORD_W     = 64;
  localparam int BIT_IDX_W  = $clog2(WORD_W);
  localparam int GAIN_W     = 14;
  localparam int TARGET_W   = 10;
  localparam int DELTA_W    = 16;
  localparam int DRIVE_W    = 8;
  localparam int POS_W      = 32;
  localparam int DTERM_W    = 24;
  localparam int SUM_W      = 48;
  localparam int FILT_W     = 48;
  localparam int Q16        = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;

  localparam int TICKS_DEF     = 40;
  localparam int GAIN_FRAC_DEF = 12;

  // 100 in Q.16
  localparam logic [DTERM_W-1:0] DRIVE_LIMIT = 24'd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INT_GAIN   = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_TARGET     = 2'd3
  } cfg_reg_t;

  // One pass of the serial multiply-add engine:
  // result = gain_a * opa + gain_b * (inv_b ? ~opb : opb) + carry_in, mod 2^WORD_W
  typedef struct packed {
    logic [WORD_W-1:0]    opa;
    logic [WORD_W-1:0]    opb;
    logic [GAIN_W-1:0]    gain_a;
    logic [GAIN_W-1:0]    gain_b;
    logic                 inv_b;
    logic                 carry_in;
    logic [BIT_IDX_W-1:0] pivot_idx;
  } mac_cmd_t;

  // Range flags collected while the result streams out
  typedef struct packed {
    logic ovf;       // some bit above pivot differs from the pivot bit
    logic pivot;     // result bit at pivot_idx
    logic low_zero;  // all bits below pivot_idx are zero
  } mac_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/ppd_serial_mac.sv
// ---------------------------------------------------------------------------
// ppd_serial_mac
// Bit-serial multiply-add: operands shift out LSB first against two
// parallel gains; one result bit per cycle into a shift register.
// ---------------------------------------------------------------------------
`default_nettype none

module ppd_serial_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  ppd_pkg::mac_cmd_t             cmd,
  output logic                          done,
  output logic [ppd_pkg::WORD_W-1:0]    result,
  output ppd_pkg::mac_flags_t           flags
);
  import ppd_pkg::*;

  localparam int ACC_W = GAIN_W + 1;
  localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(WORD_W - 1);

  logic [WORD_W-1:0]    opa_r;
  logic [WORD_W-1:0]    opb_r;
  logic [WORD_W-1:0]    res_r;
  logic [GAIN_W-1:0]    ga_r;
  logic [GAIN_W-1:0]    gb_r;
  logic                 inv_r;
  logic [ACC_W-1:0]     acc_r;
  logic [BIT_IDX_W-1:0] idx_r;
  logic [BIT_IDX_W-1:0] pivot_idx_r;
  logic                 busy_r;
  logic                 done_r;
  mac_flags_t           flags_r;

  logic                 bit_b;
  logic [ACC_W:0]       acc_sum;
  logic                 out_bit;

  // carry-save style accumulator never exceeds gain_a + gain_b + 1
  always_comb begin
    bit_b   = opb_r[0] ^ inv_r;
    acc_sum = {1'b0, acc_r}
            + (opa_r[0] ? {2'b00, ga_r} : {(ACC_W+1){1'b0}})
            + (bit_b    ? {2'b00, gb_r} : {(ACC_W+1){1'b0}});
    out_bit = acc_sum[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa_r       <= cmd.opa;
      opb_r       <= cmd.opb;
      ga_r        <= cmd.gain_a;
      gb_r        <= cmd.gain_b;
      inv_r       <= cmd.inv_b;
      acc_r       <= {{(ACC_W-1){1'b0}}, cmd.carry_in};
      pivot_idx_r <= cmd.pivot_idx;
      flags_r     <= '{ovf: 1'b0, pivot: 1'b0, low_zero: 1'b1};
    end else if (busy_r) begin
      opa_r <= opa_r >> 1;
      opb_r <= opb_r >> 1;
      acc_r <= acc_sum[ACC_W:1];
      res_r <= {out_bit, res_r[WORD_W-1:1]};
      if (idx_r < pivot_idx_r) begin
        flags_r.low_zero <= flags_r.low_zero & ~out_bit;
      end else if (idx_r == pivot_idx_r) begin
        flags_r.pivot <= out_bit;
      end else begin
        flags_r.ovf <= flags_r.ovf | (out_bit ^ flags_r.pivot);
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;
  assign flags  = flags_r;

endmodule

`default_nettype wire

// File: hw/rtl/ppd_div10.sv
// ---------------------------------------------------------------------------
// ppd_div10
// Serial long division by ten, MSB first, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ppd_div10 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ppd_pkg::WORD_W-1:0] dividend,
  output logic                       done,
  output logic [ppd_pkg::WORD_W-1:0] quotient
);
  import ppd_pkg::*;

  localparam int REM_W = 4;
  localparam logic [REM_W:0] DIVISOR = 5'd10;
  localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(WORD_W - 1);

  logic [WORD_W-1:0]    num_r;
  logic [WORD_W-1:0]    quo_r;
  logic [REM_W-1:0]     rem_r;
  logic [BIT_IDX_W-1:0] idx_r;
  logic                 busy_r;
  logic                 done_r;

  logic [REM_W:0]       partial;
  logic                 ge;
  logic [REM_W-1:0]     rem_nxt;

  always_comb begin
    partial = {rem_r, num_r[WORD_W-1]};
    ge      = (partial >= DIVISOR);
    rem_nxt = ge ? REM_W'(partial - DIVISOR) : partial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[WORD_W-2:0], 1'b0};
      quo_r <= {quo_r[WORD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/position_pid_filtered_derivative_top.sv
// ---------------------------------------------------------------------------
// position_pid_filtered_derivative_top
// Positional PID with low-pass filtered derivative, bit-serial datapath.
// ---------------------------------------------------------------------------
//
//   channel  | direction | payload (LSB first)                    | transfer
//   ---------+-----------+----------------------------------------+-----------------
//   in_*     | sink      | encoder_delta[15:0]                    | tvalid & tready
//   out_*    | source    | drive[7:0] position[39:8] dterm[63:40] | tvalid & tready
//   cfg_*    | sink      | cfg_index selects register, cfg_data   | valid & ready
//
// A tick that does not complete a count of TICKS_PER_UPDATE only counts up.
// An update tick runs eleven serial passes (each a launch, a bit-serial
// shift through the word and a store) and then an emit step; the passes
// share the single bit-serial multiply-add unit and a divide-by-ten unit.
// Reset (rst_n low, synchronous) clears all gains, target and controller state.
// The input stalls during an update; a finished result waits in the output
// register while further ticks are accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module position_pid_filtered_derivative_top #(
  parameter int TICKS_PER_UPDATE = ppd_pkg::TICKS_DEF,
  parameter int GAIN_FRAC_BITS   = ppd_pkg::GAIN_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input ticks
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppd_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] encoder_delta
  // results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ppd_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] drive, [39:8] position,
                                                     // [63:40] deriv_term
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppd_pkg::*;

  localparam int CNT_W = $clog2(TICKS_PER_UPDATE + 1);
  localparam logic [CNT_W-1:0] TICKS_LAST = CNT_W'(TICKS_PER_UPDATE);
  // gains are Q.GAIN_FRAC_BITS, internal sums are Q.16
  localparam int SHIFT = Q16 - GAIN_FRAC_BITS;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1);
  localparam logic [GAIN_W-1:0] GAIN_ZERO = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] FILT_KEEP = GAIN_W'(9);   // 0.9 = 9 / 10

  localparam logic [BIT_IDX_W-1:0] IDX_POS   = BIT_IDX_W'(POS_W - 1);
  localparam logic [BIT_IDX_W-1:0] IDX_WIDE  = BIT_IDX_W'(SUM_W - 1);
  localparam logic [BIT_IDX_W-1:0] IDX_PART  = BIT_IDX_W'(SUM_W);
  localparam logic [BIT_IDX_W-1:0] IDX_DTERM = BIT_IDX_W'(DTERM_W - 1);
  localparam logic [BIT_IDX_W-1:0] IDX_MSB   = BIT_IDX_W'(WORD_W - 1);

  localparam logic signed [DTERM_W-1:0] LIM_POS = DRIVE_LIMIT;
  localparam logic signed [DTERM_W-1:0] LIM_NEG = -DRIVE_LIMIT;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,     // position + delta
    ST_ERR,     // target - position
    ST_SUM,     // integral + error
    ST_DIFF,    // error - previous error
    ST_DERIV,   // kd * diff * scale + 9 * filtered
    ST_MAG,     // magnitude of that
    ST_DIV,     // divide by ten
    ST_SIGN,    // restore sign
    ST_DINT,    // integer part of filtered term
    ST_PART,    // kp * error + ki * integral
    ST_TOTAL,   // part * scale + filtered
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic                  go_r;
  logic [CNT_W-1:0]      tick_r;
  logic [CNT_W-1:0]      tick_inc;

  logic [GAIN_W-1:0]     kp_r;
  logic [GAIN_W-1:0]     ki_r;
  logic [GAIN_W-1:0]     kd_r;
  logic [TARGET_W-1:0]   target_r;

  logic [DELTA_W-1:0]    delta_r;
  logic [POS_W-1:0]      position_r;
  logic [POS_W-1:0]      err_now_r;
  logic [POS_W-1:0]      err_prev_r;
  logic [SUM_W-1:0]      err_sum_r;
  logic [FILT_W-1:0]     filt_r;
  logic [DTERM_W-1:0]    dterm_r;
  logic [DRIVE_W-1:0]    drive_r;
  logic                  neg_r;
  logic                  part_hi_r;
  logic                  part_lo_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  mac_cmd_t              mac_cmd;
  logic                  mac_start;
  logic                  mac_done;
  logic [WORD_W-1:0]     mac_res;
  mac_flags_t            mac_flags;

  logic                  div_start;
  logic                  div_done;
  logic [WORD_W-1:0]     div_quo;

  logic signed [DTERM_W-1:0] window_c;
  logic signed [DTERM_W-1:0] total_c;
  logic [DRIVE_W-1:0]        drive_c;

  function automatic logic [WORD_W-1:0] ext_pos(input logic [POS_W-1:0] v);
    return {{(WORD_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  function automatic logic [WORD_W-1:0] ext_wide(input logic [SUM_W-1:0] v);
    return {{(WORD_W-SUM_W){v[SUM_W-1]}}, v};
  endfunction

  // saturate a serial result to the signed width whose top bit is the pivot
  function automatic logic [POS_W-1:0] sat_pos(input logic [WORD_W-1:0] v,
                                              input mac_flags_t f);
    if (!f.ovf) return v[POS_W-1:0];
    return v[WORD_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  function automatic logic [SUM_W-1:0] sat_wide(input logic [WORD_W-1:0] v,
                                               input mac_flags_t f);
    if (!f.ovf) return v[SUM_W-1:0];
    return v[WORD_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
  endfunction

  function automatic logic [DTERM_W-1:0] sat_dterm(input logic [WORD_W-1:0] v,
                                                  input mac_flags_t f);
    if (!f.ovf) return v[DTERM_W-1:0];
    return v[WORD_W-1] ? {1'b1, {(DTERM_W-1){1'b0}}} : {1'b0, {(DTERM_W-1){1'b1}}};
  endfunction

  assign tick_inc  = tick_r + 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign mac_start = go_r && (state_r != ST_IDLE) && (state_r != ST_DIV)
                     && (state_r != ST_EMIT);
  assign div_start = go_r && (state_r == ST_DIV);

  // Operand selection for the pass about to launch
  always_comb begin
    mac_cmd           = '0;
    mac_cmd.gain_a    = GAIN_ONE;
    mac_cmd.gain_b    = GAIN_ONE;
    mac_cmd.pivot_idx = IDX_MSB;
    case (state_r)
      ST_POS: begin
        mac_cmd.opa       = ext_pos(position_r);
        mac_cmd.opb       = {{(WORD_W-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
        mac_cmd.pivot_idx = IDX_POS;
      end
      ST_ERR: begin
        mac_cmd.opa       = {{(WORD_W-TARGET_W){target_r[TARGET_W-1]}}, target_r};
        mac_cmd.opb       = ext_pos(position_r);
        mac_cmd.inv_b     = 1'b1;
        mac_cmd.carry_in  = 1'b1;
        mac_cmd.pivot_idx = IDX_POS;
      end
      ST_SUM: begin
        mac_cmd.opa       = ext_wide(err_sum_r);
        mac_cmd.opb       = ext_pos(err_now_r);
        mac_cmd.pivot_idx = IDX_WIDE;
      end
      ST_DIFF: begin
        mac_cmd.opa      = ext_pos(err_now_r);
        mac_cmd.opb      = ext_pos(err_prev_r);
        mac_cmd.inv_b    = 1'b1;
        mac_cmd.carry_in = 1'b1;
      end
      ST_DERIV: begin
        // error difference still sits in the engine's result register
        mac_cmd.opa    = mac_res << SHIFT;
        mac_cmd.gain_a = kd_r;
        mac_cmd.opb    = ext_wide(filt_r);
        mac_cmd.gain_b = FILT_KEEP;
      end
      ST_MAG: begin
        mac_cmd.gain_a   = GAIN_ZERO;
        mac_cmd.opb      = mac_res;
        mac_cmd.inv_b    = neg_r;
        mac_cmd.carry_in = neg_r;
      end
      ST_SIGN: begin
        mac_cmd.gain_a    = GAIN_ZERO;
        mac_cmd.opb       = div_quo;
        mac_cmd.inv_b     = neg_r;
        mac_cmd.carry_in  = neg_r;
        mac_cmd.pivot_idx = IDX_WIDE;
      end
      ST_DINT: begin
        // arithmetic shift by 16, then round toward zero for negatives
        mac_cmd.opa       = {{(WORD_W-FILT_W+Q16){filt_r[FILT_W-1]}}, filt_r[FILT_W-1:Q16]};
        mac_cmd.gain_b    = GAIN_ZERO;
        mac_cmd.carry_in  = filt_r[FILT_W-1] & (|filt_r[Q16-1:0]);
        mac_cmd.pivot_idx = IDX_DTERM;
      end
      ST_PART: begin
        mac_cmd.opa       = ext_pos(err_now_r);
        mac_cmd.gain_a    = kp_r;
        mac_cmd.opb       = ext_wide(err_sum_r);
        mac_cmd.gain_b    = ki_r;
        mac_cmd.pivot_idx = IDX_PART;
      end
      ST_TOTAL: begin
        mac_cmd.opa       = mac_res << SHIFT;
        mac_cmd.opb       = ext_wide(filt_r);
        mac_cmd.pivot_idx = IDX_DTERM;
      end
      default: ;
    endcase
  end

  // Clamp the total to +-100 in Q.16 and truncate toward zero
  always_comb begin
    window_c = $signed(mac_res[DTERM_W-1:0]);
    if (part_hi_r) begin
      total_c = LIM_POS;
    end else if (part_lo_r) begin
      total_c = LIM_NEG;
    end else if (mac_flags.ovf) begin
      total_c = mac_res[WORD_W-1] ? LIM_NEG : LIM_POS;
    end else if (window_c > LIM_POS) begin
      total_c = LIM_POS;
    end else if (window_c < LIM_NEG) begin
      total_c = LIM_NEG;
    end else begin
      total_c = window_c;
    end
    drive_c = total_c[DTERM_W-1:Q16]
            + DRIVE_W'(total_c[DTERM_W-1] & (|total_c[Q16-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      target_r    <= '0;
      position_r  <= '0;
      err_now_r   <= '0;
      err_prev_r  <= '0;
      err_sum_r   <= '0;
      filt_r      <= '0;
      dterm_r     <= '0;
    end else begin
      go_r <= 1'b0;

      // drop the result once the sink takes it, unless a new one replaces it
      if (out_valid_r && out_tready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:  kp_r     <= cfg_data[GAIN_W-1:0];
          REG_INT_GAIN:   ki_r     <= cfg_data[GAIN_W-1:0];
          REG_DERIV_GAIN: kd_r     <= cfg_data[GAIN_W-1:0];
          REG_TARGET:     target_r <= cfg_data[TARGET_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            if (tick_inc == TICKS_LAST) begin
              tick_r  <= '0;
              delta_r <= in_tdata[DELTA_W-1:0];
              state_r <= ST_POS;
              go_r    <= 1'b1;
            end else begin
              tick_r <= tick_inc;
            end
          end
        end
        ST_POS: begin
          if (mac_done) begin
            position_r <= sat_pos(mac_res, mac_flags);
            state_r    <= ST_ERR;
            go_r       <= 1'b1;
          end
        end
        ST_ERR: begin
          if (mac_done) begin
            err_prev_r <= err_now_r;
            err_now_r  <= sat_pos(mac_res, mac_flags);
            state_r    <= ST_SUM;
            go_r       <= 1'b1;
          end
        end
        ST_SUM: begin
          if (mac_done) begin
            // zero integral gain clears the integral
            err_sum_r <= (ki_r == GAIN_ZERO) ? '0 : sat_wide(mac_res, mac_flags);
            state_r   <= ST_DIFF;
            go_r      <= 1'b1;
          end
        end
        ST_DIFF: begin
          if (mac_done) begin
            state_r <= ST_DERIV;
            go_r    <= 1'b1;
          end
        end
        ST_DERIV: begin
          if (mac_done) begin
            neg_r   <= mac_res[WORD_W-1];
            state_r <= ST_MAG;
            go_r    <= 1'b1;
          end
        end
        ST_MAG: begin
          if (mac_done) begin
            state_r <= ST_DIV;
            go_r    <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_SIGN;
            go_r    <= 1'b1;
          end
        end
        ST_SIGN: begin
          if (mac_done) begin
            filt_r  <= sat_wide(mac_res, mac_flags);
            state_r <= ST_DINT;
            go_r    <= 1'b1;
          end
        end
        ST_DINT: begin
          if (mac_done) begin
            dterm_r <= sat_dterm(mac_res, mac_flags);
            state_r <= ST_PART;
            go_r    <= 1'b1;
          end
        end
        ST_PART: begin
          if (mac_done) begin
            // at or beyond 2^48 in magnitude the drive pins to the limit
            part_hi_r <= mac_flags.ovf & ~mac_res[WORD_W-1];
            part_lo_r <= (mac_flags.ovf & mac_res[WORD_W-1])
                       | (~mac_flags.ovf & mac_flags.pivot & mac_flags.low_zero);
            state_r   <= ST_TOTAL;
            go_r      <= 1'b1;
          end
        end
        ST_TOTAL: begin
          if (mac_done) begin
            drive_r <= drive_c;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold here until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {dterm_r, position_r, drive_r};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ppd_serial_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .cmd    (mac_cmd),
    .done   (mac_done),
    .result (mac_res),
    .flags  (mac_flags)
  );

  ppd_div10 u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mac_res),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ppd_checker.sv
// ---------------------------------------------------------------------------
// ppd_checker
// Port-level checks of the position PID block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "position_pid_filtered_derivative_top_defines.svh"

module ppd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ppd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  `PPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed or dropped while stalled")

  // drive never leaves the clamp window
  `PPD_ASSERT_SAME(a_drive_range, clk, rst_n, out_tvalid, ($signed(out_tdata[7:0]) >= -8'sd100) && ($signed(out_tdata[7:0]) <= 8'sd100), "drive outside +-100")

  // a new result appears only as an update finishes, and input reopens with it
  `PPD_ASSERT_SAME(a_emit_reopens, clk, rst_n, $rose(out_tvalid), in_tready && !$past(in_tready), "result raised outside the end of an update")

endmodule

bind position_pid_filtered_derivative_top ppd_checker u_ppd_checker (.*);

`default_nettype wire
